### hw/rtl/sgr_enc_pkg.sv
// shared types, character codes and part tables of the sgr attribute escape encoder
package sgr_enc_pkg;

    localparam int SlotCount = 18;

    typedef logic [SlotCount-1:0] slot_mask_t;
    typedef logic [4:0] slot_idx_t;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_ESC     = 8'b0000_0010,
        ST_BRACKET = 8'b0000_0100,
        ST_SEMI    = 8'b0000_1000,
        ST_HUND    = 8'b0001_0000,
        ST_TENS    = 8'b0010_0000,
        ST_ONES    = 8'b0100_0000,
        ST_FINAL   = 8'b1000_0000
    } enc_state_t;

    localparam logic [1:0] MODE_DEFAULT = 2'd0;
    localparam logic [1:0] MODE_PALETTE = 2'd1;
    localparam logic [1:0] MODE_RGB     = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    localparam logic [7:0] CHAR_ESC     = 8'h1b;
    localparam logic [7:0] CHAR_BRACKET = 8'h5b;
    localparam logic [7:0] CHAR_SEMI    = 8'h3b;
    localparam logic [7:0] CHAR_M       = 8'h6d;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;

    localparam logic [7:0] FORE_BASE   = 8'd30;
    localparam logic [7:0] FORE_BRIGHT = 8'd90;
    localparam logic [7:0] FORE_EXT    = 8'd38;
    localparam logic [7:0] BACK_BASE   = 8'd40;
    localparam logic [7:0] BACK_BRIGHT = 8'd100;
    localparam logic [7:0] BACK_EXT    = 8'd48;
    localparam logic [7:0] PART_RESET   = 8'd0;
    localparam logic [7:0] PART_PALETTE = 8'd5;
    localparam logic [7:0] PART_RGB     = 8'd2;
    localparam logic [7:0] DEFAULT_OFFSET = 8'd9;

    localparam logic [7:0] STYLE_CODE [7] = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd7, 8'd9};

    // slot layout: reset part, seven style parts, five foreground, five background
    localparam slot_idx_t SLOT_STYLE = 5'd1;
    localparam slot_idx_t SLOT_FORE  = 5'd8;
    localparam slot_idx_t SLOT_BACK  = 5'd13;

    function automatic logic [11:0] to_bcd(input logic [7:0] v);
        logic [19:0] sh;
        sh = {12'b0, v};
        for (int i = 0; i < 8; i++) begin
            if (sh[11:8] >= 4'd5) sh[11:8] = sh[11:8] + 4'd3;
            if (sh[15:12] >= 4'd5) sh[15:12] = sh[15:12] + 4'd3;
            if (sh[19:16] >= 4'd5) sh[19:16] = sh[19:16] + 4'd3;
            sh = sh << 1;
        end
        return sh[19:8];
    endfunction

    function automatic logic [4:0] colour_mask(input logic [1:0] mode, input logic [23:0] value);
        logic [4:0] m;
        case (mode)
            MODE_PALETTE: m = (value[7:0] >= 8'd16) ? 5'b00111 : 5'b00001;
            MODE_RGB:     m = 5'b11111;
            default:      m = 5'b00001;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] colour_part(input logic [1:0] mode, input logic [23:0] value,
                                               input logic [2:0] pos, input logic [7:0] base,
                                               input logic [7:0] bright, input logic [7:0] ext);
        logic [7:0] idx;
        logic [7:0] part;
        idx  = value[7:0];
        part = '0;
        case (mode)
            MODE_PALETTE: begin
                case (pos)
                    3'd0: begin
                        if (idx < 8'd8) part = base + idx;
                        else if (idx < 8'd16) part = bright + idx - 8'd8;
                        else part = ext;
                    end
                    3'd1:    part = PART_PALETTE;
                    3'd2:    part = idx;
                    default: part = '0;
                endcase
            end
            MODE_RGB: begin
                case (pos)
                    3'd0:    part = ext;
                    3'd1:    part = PART_RGB;
                    3'd2:    part = value[23:16];
                    3'd3:    part = value[15:8];
                    3'd4:    part = value[7:0];
                    default: part = '0;
                endcase
            end
            default: part = base + DEFAULT_OFFSET;
        endcase
        return part;
    endfunction

    function automatic logic [7:0] slot_value(input slot_idx_t slot,
                                              input logic [1:0] fm, input logic [23:0] fv,
                                              input logic [1:0] bm, input logic [23:0] bv);
        logic [7:0] v;
        if (slot < SLOT_STYLE) begin
            v = PART_RESET;
        end else if (slot < SLOT_FORE) begin
            v = STYLE_CODE[3'(slot - SLOT_STYLE)];
        end else if (slot < SLOT_BACK) begin
            v = colour_part(fm, fv, 3'(slot - SLOT_FORE), FORE_BASE, FORE_BRIGHT, FORE_EXT);
        end else begin
            v = colour_part(bm, bv, 3'(slot - SLOT_BACK), BACK_BASE, BACK_BRIGHT, BACK_EXT);
        end
        return v;
    endfunction

endpackage

### hw/rtl/sgr_attribute_escape_encoder_unit.sv
// top level of the sgr attribute escape encoder
// Each accepted item is compared with the attributes of the item before it and, when
// anything differs (or use_previous is low), turns into an ESC [ ... m sequence of 5 to
// 52 bytes, one byte per cycle on the m_ side while m_tready does not stall the output,
// the final 'm' flagged by m_tlast. An unchanged item is taken and yields nothing.
// Otherwise the bytes of the item are paced by the single byte sequencer that walks the
// parts and splits each into decimal digits; s_tready stays low until the 'm' has been
// handed to the output register.
module sgr_attribute_escape_encoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // fore_mode[1:0], fore_value[25:2], back_mode[27:26], back_value[51:28],
    // style_flags[58:52], use_previous[59], zero fill[63:60]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_byte[7:0]
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    sgr_enc_pkg::enc_state_t state_reg, state_next;
    sgr_enc_pkg::slot_mask_t mask_reg, mask_next;
    logic [11:0] bcd_reg, bcd_next;
    logic [1:0]  fore_mode_reg, fore_mode_next;
    logic [23:0] fore_value_reg, fore_value_next;
    logic [1:0]  back_mode_reg, back_mode_next;
    logic [23:0] back_value_reg, back_value_next;
    logic [6:0]  style_reg, style_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;

    logic [1:0]  in_fore_mode, in_back_mode;
    logic [23:0] in_fore_value, in_back_value;
    logic [6:0]  in_style;
    logic        in_use_previous;
    logic        fore_same, back_same, fore_ch, back_ch, style_ch;
    logic        advance;
    logic        emit;
    logic [7:0]  emit_byte;
    logic        emit_last;
    sgr_enc_pkg::slot_idx_t first_slot;
    logic [11:0] part_bcd;
    sgr_enc_pkg::enc_state_t digit_state;

    assign in_fore_mode    = (s_tdata[1:0] == sgr_enc_pkg::MODE_UNUSED) ?
                             sgr_enc_pkg::MODE_DEFAULT : s_tdata[1:0];
    assign in_fore_value   = s_tdata[25:2];
    assign in_back_mode    = (s_tdata[27:26] == sgr_enc_pkg::MODE_UNUSED) ?
                             sgr_enc_pkg::MODE_DEFAULT : s_tdata[27:26];
    assign in_back_value   = s_tdata[51:28];
    assign in_style        = s_tdata[58:52];
    assign in_use_previous = s_tdata[59];

    always_comb begin
        fore_same = (in_fore_mode == fore_mode_reg);
        if (in_fore_mode == sgr_enc_pkg::MODE_PALETTE)
            fore_same = fore_same && (in_fore_value[7:0] == fore_value_reg[7:0]);
        else if (in_fore_mode == sgr_enc_pkg::MODE_RGB)
            fore_same = fore_same && (in_fore_value == fore_value_reg);
        back_same = (in_back_mode == back_mode_reg);
        if (in_back_mode == sgr_enc_pkg::MODE_PALETTE)
            back_same = back_same && (in_back_value[7:0] == back_value_reg[7:0]);
        else if (in_back_mode == sgr_enc_pkg::MODE_RGB)
            back_same = back_same && (in_back_value == back_value_reg);
    end

    assign style_ch = !in_use_previous || (in_style != style_reg);
    assign fore_ch  = !in_use_previous || !fore_same || style_ch;
    assign back_ch  = !in_use_previous || !back_same || style_ch;

    // lowest pending part
    always_comb begin
        first_slot = '0;
        for (int i = sgr_enc_pkg::SlotCount - 1; i >= 0; i--) begin
            if (mask_reg[i]) first_slot = sgr_enc_pkg::slot_idx_t'(i);
        end
    end

    assign part_bcd = sgr_enc_pkg::to_bcd(sgr_enc_pkg::slot_value(first_slot,
                          fore_mode_reg, fore_value_reg, back_mode_reg, back_value_reg));

    always_comb begin
        if (part_bcd[11:8] != 4'd0) digit_state = sgr_enc_pkg::ST_HUND;
        else if (part_bcd[7:4] != 4'd0) digit_state = sgr_enc_pkg::ST_TENS;
        else digit_state = sgr_enc_pkg::ST_ONES;
    end

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == sgr_enc_pkg::ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        mask_next       = mask_reg;
        bcd_next        = bcd_reg;
        fore_mode_next  = fore_mode_reg;
        fore_value_next = fore_value_reg;
        back_mode_next  = back_mode_reg;
        back_value_next = back_value_reg;
        style_next      = style_reg;
        emit            = 1'b0;
        emit_byte       = sgr_enc_pkg::CHAR_ZERO;
        emit_last       = 1'b0;
        case (state_reg)
            sgr_enc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    fore_mode_next  = in_fore_mode;
                    fore_value_next = in_fore_value;
                    back_mode_next  = in_back_mode;
                    back_value_next = in_back_value;
                    style_next      = in_style;
                    mask_next = {back_ch ? sgr_enc_pkg::colour_mask(in_back_mode, in_back_value)
                                         : 5'b0,
                                 fore_ch ? sgr_enc_pkg::colour_mask(in_fore_mode, in_fore_value)
                                         : 5'b0,
                                 in_style, style_ch};
                    if (fore_ch || back_ch) state_next = sgr_enc_pkg::ST_ESC;
                end
            end
            sgr_enc_pkg::ST_ESC: begin
                if (advance) begin
                    emit       = 1'b1;
                    emit_byte  = sgr_enc_pkg::CHAR_ESC;
                    state_next = sgr_enc_pkg::ST_BRACKET;
                end
            end
            sgr_enc_pkg::ST_BRACKET, sgr_enc_pkg::ST_SEMI: begin
                if (advance) begin
                    emit       = 1'b1;
                    emit_byte  = (state_reg == sgr_enc_pkg::ST_SEMI) ?
                                 sgr_enc_pkg::CHAR_SEMI : sgr_enc_pkg::CHAR_BRACKET;
                    bcd_next   = part_bcd;
                    mask_next  = mask_reg & ~(sgr_enc_pkg::slot_mask_t'(1) << first_slot);
                    state_next = digit_state;
                end
            end
            sgr_enc_pkg::ST_HUND: begin
                if (advance) begin
                    emit       = 1'b1;
                    emit_byte  = sgr_enc_pkg::CHAR_ZERO | {4'b0, bcd_reg[11:8]};
                    state_next = sgr_enc_pkg::ST_TENS;
                end
            end
            sgr_enc_pkg::ST_TENS: begin
                if (advance) begin
                    emit       = 1'b1;
                    emit_byte  = sgr_enc_pkg::CHAR_ZERO | {4'b0, bcd_reg[7:4]};
                    state_next = sgr_enc_pkg::ST_ONES;
                end
            end
            sgr_enc_pkg::ST_ONES: begin
                if (advance) begin
                    emit       = 1'b1;
                    emit_byte  = sgr_enc_pkg::CHAR_ZERO | {4'b0, bcd_reg[3:0]};
                    state_next = (mask_reg != '0) ? sgr_enc_pkg::ST_SEMI : sgr_enc_pkg::ST_FINAL;
                end
            end
            sgr_enc_pkg::ST_FINAL: begin
                if (advance) begin
                    emit       = 1'b1;
                    emit_byte  = sgr_enc_pkg::CHAR_M;
                    emit_last  = 1'b1;
                    state_next = sgr_enc_pkg::ST_IDLE;
                end
            end
            default: state_next = sgr_enc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (advance) begin
            out_valid_next = emit;
            out_data_next  = emit_byte;
            out_last_next  = emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sgr_enc_pkg::ST_IDLE;
            out_valid_reg  <= 1'b0;
            fore_mode_reg  <= sgr_enc_pkg::MODE_DEFAULT;
            fore_value_reg <= '0;
            back_mode_reg  <= sgr_enc_pkg::MODE_DEFAULT;
            back_value_reg <= '0;
            style_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            fore_mode_reg  <= fore_mode_next;
            fore_value_reg <= fore_value_next;
            back_mode_reg  <= back_mode_next;
            back_value_reg <= back_value_next;
            style_reg      <= style_next;
        end
    end

    always_ff @(posedge aclk) begin
        mask_reg     <= mask_next;
        bcd_reg      <= bcd_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

### hw/rtl/sgr_enc_checker.sv
// port level checks of the sgr attribute escape encoder and their bind
module sgr_enc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // a stalled item holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output item changed");

    // sequence ends on 'm' and 'm' appears nowhere else
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata == sgr_enc_pkg::CHAR_M)))
        else $error("last flag and terminator disagree");

    // no new item taken in the middle of a sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid || m_tlast)
        else $error("input ready while a sequence is open");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind sgr_attribute_escape_encoder_unit sgr_enc_checker u_sgr_enc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### bench/tb_top.sv
// self-checking stream testbench for the sgr attribute escape encoder unit
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumRows     = 23;
    localparam int RandomCells = 207;
    localparam int CycleLimit  = 400000;
    localparam int DrainCycles = 60;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // fore_mode[1:0], fore_value[25:2], back_mode[27:26], back_value[51:28],
    // style_flags[58:52], use_previous[59], zero fill[63:60]
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // out_byte[7:0]
    logic [7:0]  m_tdata;
    logic        m_tlast;

    sgr_attribute_escape_encoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // attributes kept from the previous cell
    logic [1:0]  kept_fm;
    logic [23:0] kept_fv;
    logic [1:0]  kept_bm;
    logic [23:0] kept_bv;
    logic [6:0]  kept_st;

    logic [7:0]  seq_bytes[$];
    bit          seq_open;
    out_beat_t   expected_bytes[$];
    out_beat_t   want;
    int          errors = 0;
    int          cycles = 0;
    int          burst_left = 0;

    logic [63:0] row_word[NumRows];
    bit          row_typed[NumRows];
    string       row_text[NumRows];
    logic [63:0] last_word;

    function automatic logic [63:0] pack_cell(input logic [1:0] fm, input logic [23:0] fv,
                                              input logic [1:0] bm, input logic [23:0] bv,
                                              input logic [6:0] st, input logic prev);
        return {4'b0, prev, st, bv, bm, fv, fm};
    endfunction

    function automatic void add_decimal_part(input logic [7:0] v);
        if (seq_open) seq_bytes.push_back(sgr_enc_pkg::CHAR_SEMI);
        seq_open = 1'b1;
        if (v >= 8'd100) seq_bytes.push_back(8'(sgr_enc_pkg::CHAR_ZERO + v / 8'd100));
        if (v >= 8'd10) seq_bytes.push_back(8'(sgr_enc_pkg::CHAR_ZERO + (v / 8'd10) % 8'd10));
        seq_bytes.push_back(8'(sgr_enc_pkg::CHAR_ZERO + v % 8'd10));
    endfunction

    function automatic void add_colour(input logic [1:0] mode, input logic [23:0] value,
                                       input logic [7:0] base, input logic [7:0] bright,
                                       input logic [7:0] ext);
        logic [7:0] idx;
        idx = value[7:0];
        case (mode)
            sgr_enc_pkg::MODE_PALETTE: begin
                if (idx < 8'd8) begin
                    add_decimal_part(8'(base + idx));
                end else if (idx < 8'd16) begin
                    add_decimal_part(8'(bright + idx - 8'd8));
                end else begin
                    add_decimal_part(ext);
                    add_decimal_part(sgr_enc_pkg::PART_PALETTE);
                    add_decimal_part(idx);
                end
            end
            sgr_enc_pkg::MODE_RGB: begin
                add_decimal_part(ext);
                add_decimal_part(sgr_enc_pkg::PART_RGB);
                add_decimal_part(value[23:16]);
                add_decimal_part(value[15:8]);
                add_decimal_part(value[7:0]);
            end
            default: add_decimal_part(8'(base + sgr_enc_pkg::DEFAULT_OFFSET));
        endcase
    endfunction

    function automatic bit same_colour(input logic [1:0] ma, input logic [23:0] va,
                                       input logic [1:0] mb, input logic [23:0] vb);
        if (ma != mb) return 1'b0;
        if (ma == sgr_enc_pkg::MODE_PALETTE) return va[7:0] == vb[7:0];
        if (ma == sgr_enc_pkg::MODE_RGB) return va == vb;
        return 1'b1;
    endfunction

    // fills seq_bytes with the sequence one cell causes and updates the kept attributes
    function automatic void predict_cell(input logic [1:0] fm_in, input logic [23:0] fv,
                                         input logic [1:0] bm_in, input logic [23:0] bv,
                                         input logic [6:0] st, input logic prev);
        logic [1:0] fm;
        logic [1:0] bm;
        bit fore_new;
        bit back_new;
        bit style_new;
        fm = (fm_in == sgr_enc_pkg::MODE_UNUSED) ? sgr_enc_pkg::MODE_DEFAULT : fm_in;
        bm = (bm_in == sgr_enc_pkg::MODE_UNUSED) ? sgr_enc_pkg::MODE_DEFAULT : bm_in;
        fore_new  = !prev || !same_colour(fm, fv, kept_fm, kept_fv);
        back_new  = !prev || !same_colour(bm, bv, kept_bm, kept_bv);
        style_new = !prev || (st != kept_st);
        kept_fm = fm;
        kept_fv = fv;
        kept_bm = bm;
        kept_bv = bv;
        kept_st = st;
        seq_bytes.delete();
        seq_open = 1'b0;
        if (!fore_new && !back_new && !style_new) return;
        seq_bytes.push_back(sgr_enc_pkg::CHAR_ESC);
        seq_bytes.push_back(sgr_enc_pkg::CHAR_BRACKET);
        if (style_new) begin
            add_decimal_part(sgr_enc_pkg::PART_RESET);
            fore_new = 1'b1;
            back_new = 1'b1;
        end
        for (int i = 0; i < 7; i++) begin
            if (st[i]) add_decimal_part(sgr_enc_pkg::STYLE_CODE[i]);
        end
        if (fore_new) begin
            add_colour(fm, fv, sgr_enc_pkg::FORE_BASE, sgr_enc_pkg::FORE_BRIGHT,
                       sgr_enc_pkg::FORE_EXT);
        end
        if (back_new) begin
            add_colour(bm, bv, sgr_enc_pkg::BACK_BASE, sgr_enc_pkg::BACK_BRIGHT,
                       sgr_enc_pkg::BACK_EXT);
        end
        seq_bytes.push_back(sgr_enc_pkg::CHAR_M);
    endfunction

    function automatic logic [23:0] random_colour_value(input logic [1:0] mode);
        logic [31:0] r;
        logic [7:0]  idx;
        r = $urandom();
        if (mode == sgr_enc_pkg::MODE_PALETTE) begin
            case ($urandom_range(0, 3))
                0: idx = {5'b0, r[2:0]};
                1: idx = {5'b00001, r[2:0]};
                2: idx = r[7:0];
                default: idx = r[31] ? 8'hff : 8'h10;
            endcase
            return {r[23:8], idx};
        end
        if ($urandom_range(0, 7) == 0) return r[24] ? 24'hffffff : 24'h000000;
        return r[23:0];
    endfunction

    // mostly small changes against the last cell, some repeats, some with no previous cell
    function automatic logic [63:0] random_cell_word();
        logic [1:0]  fm;
        logic [23:0] fv;
        logic [1:0]  bm;
        logic [23:0] bv;
        logic [6:0]  st;
        logic        prev;
        int          kind;
        fm = last_word[1:0];
        fv = last_word[25:2];
        bm = last_word[27:26];
        bv = last_word[51:28];
        st = last_word[58:52];
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            prev = 1'b1;
            if (fm == sgr_enc_pkg::MODE_DEFAULT || fm == sgr_enc_pkg::MODE_UNUSED) begin
                fm = $urandom_range(0, 1) ? sgr_enc_pkg::MODE_DEFAULT : sgr_enc_pkg::MODE_UNUSED;
                fv = 24'($urandom());
            end else if (fm == sgr_enc_pkg::MODE_PALETTE) begin
                fv[23:8] = 16'($urandom());
            end
            if (bm == sgr_enc_pkg::MODE_DEFAULT || bm == sgr_enc_pkg::MODE_UNUSED) begin
                bm = $urandom_range(0, 1) ? sgr_enc_pkg::MODE_DEFAULT : sgr_enc_pkg::MODE_UNUSED;
                bv = 24'($urandom());
            end else if (bm == sgr_enc_pkg::MODE_PALETTE) begin
                bv[23:8] = 16'($urandom());
            end
        end else begin
            prev = (kind >= 28);
            if ($urandom_range(0, 2) == 0) st = 7'($urandom_range(0, 127));
            if ($urandom_range(0, 1) == 1) begin
                fm = 2'($urandom_range(0, 3));
                fv = random_colour_value(fm);
            end
            if ($urandom_range(0, 1) == 1) begin
                bm = 2'($urandom_range(0, 3));
                bv = random_colour_value(bm);
            end
        end
        return pack_cell(fm, fv, bm, bv, st, prev);
    endfunction

    task automatic set_row(input int r, input logic [1:0] fm, input logic [23:0] fv,
                           input logic [1:0] bm, input logic [23:0] bv, input logic [6:0] st,
                           input logic prev, input bit typed, input string text);
        row_word[r]  = pack_cell(fm, fv, bm, bv, st, prev);
        row_typed[r] = typed;
        row_text[r]  = text;
    endtask

    task automatic drive_cell(input logic [63:0] word, input bit typed, input string text,
                              input bit last_cell);
        out_beat_t beat;
        int        gap;
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_cell(word[1:0], word[25:2], word[27:26], word[51:28], word[58:52], word[59]);
        if (typed) begin
            for (int i = 0; i < text.len(); i++) begin
                beat.data = text[i];
                beat.last = (i == text.len() - 1);
                expected_bytes.push_back(beat);
            end
        end else begin
            for (int i = 0; i < seq_bytes.size(); i++) begin
                beat.data = seq_bytes[i];
                beat.last = (i == seq_bytes.size() - 1);
                expected_bytes.push_back(beat);
            end
        end
        if (last_cell) begin
            s_tvalid <= 1'b0;
        end else if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    // receiver stall pattern: free running, coin flip, periodic, mostly stalled
    always @(posedge aclk) begin
        case ((cycles / 97) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (cycles % 5 != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: expected no item, got byte %h last %b", $time, m_tdata, m_tlast);
                errors++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.data || m_tlast !== want.last) begin
                    $display("%0t: expected byte %h last %b, got byte %h last %b",
                             $time, want.data, want.last, m_tdata, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("sgr_attribute_escape_encoder_unit verification failed");
            $finish;
        end
    end

    initial begin
        kept_fm = sgr_enc_pkg::MODE_DEFAULT;
        kept_fv = '0;
        kept_bm = sgr_enc_pkg::MODE_DEFAULT;
        kept_bv = '0;
        kept_st = '0;
        set_row(0, sgr_enc_pkg::MODE_DEFAULT, 24'h0, sgr_enc_pkg::MODE_DEFAULT, 24'h0,
                7'h00, 1'b0, 1, "\033[0;39;49m");
        set_row(1, sgr_enc_pkg::MODE_DEFAULT, 24'h0, sgr_enc_pkg::MODE_DEFAULT, 24'h0,
                7'h00, 1'b1, 1, "");
        set_row(2, sgr_enc_pkg::MODE_PALETTE, 24'h0, sgr_enc_pkg::MODE_PALETTE, 24'h0,
                7'h00, 1'b1, 1, "\033[30;40m");
        set_row(3, sgr_enc_pkg::MODE_PALETTE, 24'd7, sgr_enc_pkg::MODE_PALETTE, 24'd8,
                7'h00, 1'b1, 1, "\033[37;100m");
        set_row(4, sgr_enc_pkg::MODE_PALETTE, 24'd15, sgr_enc_pkg::MODE_PALETTE, 24'd16,
                7'h00, 1'b1, 1, "\033[97;48;5;16m");
        set_row(5, sgr_enc_pkg::MODE_PALETTE, 24'hffffff, sgr_enc_pkg::MODE_PALETTE, 24'hffffff,
                7'h00, 1'b1, 1, "\033[38;5;255;48;5;255m");
        set_row(6, sgr_enc_pkg::MODE_PALETTE, 24'h0000ff, sgr_enc_pkg::MODE_PALETTE, 24'h1234ff,
                7'h00, 1'b1, 1, "");
        set_row(7, sgr_enc_pkg::MODE_RGB, 24'hffffff, sgr_enc_pkg::MODE_RGB, 24'hffffff,
                7'h00, 1'b1, 1, "\033[38;2;255;255;255;48;2;255;255;255m");
        set_row(8, sgr_enc_pkg::MODE_RGB, 24'h0, sgr_enc_pkg::MODE_RGB, 24'h0,
                7'h00, 1'b1, 1, "\033[38;2;0;0;0;48;2;0;0;0m");
        set_row(9, sgr_enc_pkg::MODE_RGB, 24'hffffff, sgr_enc_pkg::MODE_RGB, 24'hffffff,
                7'h7f, 1'b1, 1, "\033[0;1;2;3;4;5;7;9;38;2;255;255;255;48;2;255;255;255m");
        set_row(10, sgr_enc_pkg::MODE_RGB, 24'hffffff, sgr_enc_pkg::MODE_RGB, 24'hffffff,
                7'h7f, 1'b1, 1, "");
        set_row(11, sgr_enc_pkg::MODE_UNUSED, 24'habcdef, sgr_enc_pkg::MODE_UNUSED, 24'hffffff,
                7'h7f, 1'b1, 1, "\033[1;2;3;4;5;7;9;39;49m");
        set_row(12, sgr_enc_pkg::MODE_DEFAULT, 24'h0, sgr_enc_pkg::MODE_DEFAULT, 24'h123456,
                7'h7f, 1'b1, 1, "");
        set_row(13, sgr_enc_pkg::MODE_DEFAULT, 24'h0, sgr_enc_pkg::MODE_DEFAULT, 24'h0,
                7'h00, 1'b1, 1, "\033[0;39;49m");
        for (int i = 0; i < 7; i++) begin
            set_row(14 + i, sgr_enc_pkg::MODE_PALETTE, 24'(i * 37), sgr_enc_pkg::MODE_RGB,
                    24'(i * 24'h010203), 7'(1 << i), 1'b1, 0, "");
        end
        set_row(21, sgr_enc_pkg::MODE_RGB, 24'h123456, sgr_enc_pkg::MODE_PALETTE, 24'd200,
                7'h55, 1'b0, 0, "");
        set_row(22, sgr_enc_pkg::MODE_DEFAULT, 24'h0, sgr_enc_pkg::MODE_PALETTE, 24'd200,
                7'h55, 1'b1, 0, "");

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        burst_left = $urandom_range(0, 15);
        for (int r = 0; r < NumRows; r++) begin
            drive_cell(row_word[r], row_typed[r], row_text[r], 1'b0);
        end
        last_word = row_word[NumRows-1];
        for (int n = 0; n < RandomCells; n++) begin
            last_word = random_cell_word();
            drive_cell(last_word, 1'b0, "", n == RandomCells - 1);
        end
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        if (errors == 0) begin
            $display("sgr_attribute_escape_encoder_unit verification clean");
        end else begin
            $display("sgr_attribute_escape_encoder_unit verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/sgr_enc_pkg.sv
hw/rtl/sgr_attribute_escape_encoder_unit.sv
hw/rtl/sgr_enc_checker.sv
bench/tb_top.sv
